// ----- rtl/core/ptrh_pkg.sv -----
// Shared types and constants for the panel table ray hit test block.
package ptrh_pkg;

  localparam int SLOTS     = 32;
  localparam int FRAC_BITS = 16;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MIN_DZ    = ((1 << FRAC_BITS) + 9999) / 10000;
  localparam int Q_W       = 41;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_SET_POS = 3'd1;
  localparam logic [2:0] OP_PIN     = 3'd2;
  localparam logic [2:0] OP_SHOW    = 3'd3;
  localparam logic [2:0] OP_RAYCAST = 3'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        panel_id;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        width;
    logic [30:0]        height;
    logic [30:0]        distance;
    logic               visible;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [31:0]        new_panel_id;
    logic               hit;
    logic [31:0]        hit_panel_id;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [32:0] b;
    logic [31:0] dz;
  } md_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } md_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_RC_TEST, ST_RC_X, ST_RC_Y, ST_RC_EVAL, ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    MD_IDLE, MD_MUL, MD_CHK, MD_DIV, MD_DONE
  } md_state_e;

endpackage

// ----- rtl/core/ptrh_muldiv.sv -----
// Shared iterative unit computing min(a * b / dz, 2^40) on magnitudes.
module ptrh_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptrh_pkg::md_req_t md_req_i,
  output ptrh_pkg::md_rsp_t md_rsp_o
);
  import ptrh_pkg::*;

  md_state_e      state_q, state_d;
  logic [5:0]     cnt_q;
  logic [31:0]    a_q, dz_q, rem_q;
  logic [47:0]    b_q;
  logic [64:0]    acc_q;
  logic [Q_W-1:0] lo_q;
  logic [15:0]    chunk;
  logic [64:0]    part;
  logic [32:0]    trial;
  logic           ge;
  logic [32:0]    diff;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    chunk = b_q[15:0];
      2'd1:    chunk = b_q[31:16];
      default: chunk = b_q[47:32];
    endcase
    part  = 65'(a_q * chunk) << {cnt_q[1:0], 4'b0000};
    trial = {rem_q, lo_q[Q_W-1]};
    ge    = trial >= {1'b0, dz_q};
    diff  = trial - {1'b0, dz_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE: if (md_req_i.start) state_d = MD_MUL;
      MD_MUL:  if (cnt_q[1:0] == 2'd2) state_d = MD_CHK;
      MD_CHK: begin
        if ({8'b0, acc_q} >= {dz_q, 41'b0}) state_d = MD_DONE;
        else state_d = MD_DIV;
      end
      MD_DIV:  if (cnt_q == 6'(Q_W - 1)) state_d = MD_DONE;
      MD_DONE: state_d = md_req_i.start ? MD_MUL : MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE, MD_DONE: begin
        a_q   <= md_req_i.a;
        b_q   <= {15'b0, md_req_i.b};
        dz_q  <= md_req_i.dz;
        acc_q <= '0;
        cnt_q <= '0;
      end
      MD_MUL: begin
        acc_q <= acc_q + part;
        cnt_q <= cnt_q + 6'd1;
      end
      MD_CHK: begin
        cnt_q <= '0;
        if ({8'b0, acc_q} >= {dz_q, 41'b0}) begin
          lo_q <= Q_W'(1) << (Q_W - 1);
        end else begin
          rem_q <= {8'b0, acc_q[64:41]};
          lo_q  <= acc_q[40:0];
        end
      end
      MD_DIV: begin
        rem_q <= ge ? diff[31:0] : trial[31:0];
        lo_q  <= {lo_q[Q_W-2:0], ge};
        cnt_q <= cnt_q + 6'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    md_rsp_o.done = (state_q == MD_DONE);
    if (lo_q[Q_W-1] && (lo_q[Q_W-2:0] != '0)) md_rsp_o.q = Q_W'(1) << (Q_W - 1);
    else md_rsp_o.q = lo_q;
  end

  ap_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp_o.done |=> !md_rsp_o.done)
    else $error("unit done held longer than one cycle");
  ap_q_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp_o.done |-> !(md_rsp_o.q[Q_W-1] && md_rsp_o.q[Q_W-2:0] != '0))
    else $error("offset above clamp");
  ap_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req_i.start |-> (state_q == MD_IDLE || state_q == MD_DONE))
    else $error("unit started while busy");

endmodule

// ----- rtl/core/panel_table_ray_hit_test.sv -----
// Top level of the panel table with nearest ray hit test.
//
// A request enters on req_valid_i/req_ready_o with payload req_i; one
// response leaves on rsp_valid_o/rsp_ready_i with payload rsp_o.
// The block works on one request at a time and is ready only when idle.
// Create, set position, pin and show scan the slots one per cycle. A
// raycast with |dir_z| of at least MIN_DZ visits every slot, one that is
// below MIN_DZ visits none and reports no hit. A slot that is free, hidden
// or behind the origin is skipped; a candidate goes through the shared
// multiply and divide unit (three 16-bit partial products, a range check
// and 41 restoring divide steps per axis).
// The response sits in an output register; if the receiver stalls, the
// block holds the next result until the register frees and meanwhile
// accepts no request. Reset empties the table and sets the id counter to
// one; no clearing pass is needed.
module panel_table_ray_hit_test (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  ptrh_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output ptrh_pkg::rsp_t rsp_o
);
  import ptrh_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   res_q, rsp_q, rsp_d;
  logic   rsp_valid_q;
  logic [SLOT_W-1:0] slot_q;

  logic [SLOTS-1:0]   valid_q, shown_q, pinned_q;
  logic [31:0]        owner_q [SLOTS];
  logic signed [31:0] cx_q [SLOTS];
  logic signed [31:0] cy_q [SLOTS];
  logic signed [31:0] cz_q [SLOTS];
  logic [30:0]        ew_q [SLOTS];
  logic [30:0]        eh_q [SLOTS];
  logic [31:0]        id_ctr_q, id_next;

  logic signed [32:0] num_q, num_c;
  logic [32:0]        num_mag_c, num_q_mag, best_q;
  logic signed [41:0] offx_q, off_c;
  logic               found_q;
  logic [31:0]        bid_q;
  logic signed [42:0] bx_q, by_q, px_c, py_c;
  logic signed [42:0] hx_q, hy_q;
  logic signed [31:0] bz_q;
  logic signed [43:0] lx_c, ly_c;
  logic [43:0]        lx_mag, ly_mag;
  logic               cand_c, in_c, better_c, last_c, accept, match_c;
  logic [31:0]        dz_mag, dx_mag, dy_mag;
  logic               axis_neg;

  md_req_t md_req;
  md_rsp_t md_rsp;

  ptrh_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .md_req_i(md_req),
    .md_rsp_o(md_rsp)
  );

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v[42:31] == '0 || v[42:31] == '1) sat32 = v[31:0];
    else if (v[42]) sat32 = 32'sh8000_0000;
    else sat32 = 32'sh7FFF_FFFF;
  endfunction

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign last_c      = (slot_q == SLOT_W'(SLOTS - 1));
  assign id_next     = (id_ctr_q == 32'hFFFF_FFFF) ? 32'd1 : id_ctr_q + 32'd1;

  always_comb begin
    dz_mag    = mag32(req_q.dir_z);
    dx_mag    = mag32(req_q.dir_x);
    dy_mag    = mag32(req_q.dir_y);
    num_c     = {cz_q[slot_q][31], cz_q[slot_q]} - {req_q.vec_z[31], req_q.vec_z};
    num_mag_c = num_c[32] ? 33'(-num_c) : 33'(num_c);
    num_q_mag = num_q[32] ? 33'(-num_q) : 33'(num_q);
    cand_c    = valid_q[slot_q] && shown_q[slot_q] &&
                ((num_c == '0) || (num_c[32] == req_q.dir_z[31]));
    match_c   = valid_q[slot_q] && (owner_q[slot_q] == req_q.panel_id) &&
                (req_q.panel_id != '0);
    axis_neg  = ((state_q == ST_RC_X) ? req_q.dir_x[31] : req_q.dir_y[31]) ^
                num_q[32] ^ req_q.dir_z[31];
    off_c     = axis_neg ? -$signed({1'b0, md_rsp.q}) : $signed({1'b0, md_rsp.q});
    px_c      = 43'(req_q.vec_x) + 43'(offx_q);
    py_c      = 43'(req_q.vec_y) + 43'(off_c);
    lx_c      = 44'(hx_q) - 44'(cx_q[slot_q]);
    ly_c      = 44'(hy_q) - 44'(cy_q[slot_q]);
    lx_mag    = lx_c[43] ? 44'(-lx_c) : 44'(lx_c);
    ly_mag    = ly_c[43] ? 44'(-ly_c) : 44'(ly_c);
    in_c      = ({lx_mag, 1'b0} <= {14'b0, ew_q[slot_q]}) &&
                ({ly_mag, 1'b0} <= {14'b0, eh_q[slot_q]});
    better_c  = !found_q || (num_q_mag < best_q);

    md_req.start = ((state_q == ST_RC_TEST) && cand_c) ||
                   ((state_q == ST_RC_X) && md_rsp.done);
    md_req.a     = (state_q == ST_RC_TEST) ? dx_mag : dy_mag;
    md_req.b     = (state_q == ST_RC_TEST) ? num_mag_c : num_q_mag;
    md_req.dz    = dz_mag;

    rsp_d = res_q;
    if (req_q.opcode == OP_RAYCAST && found_q) begin
      rsp_d.hit          = 1'b1;
      rsp_d.hit_panel_id = bid_q;
      rsp_d.hit_x        = sat32(bx_q);
      rsp_d.hit_y        = sat32(by_q);
      rsp_d.hit_z        = bz_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.opcode == OP_RAYCAST) begin
            if (mag32(req_i.dir_z) >= 32'(MIN_DZ)) state_d = ST_RC_TEST;
            else state_d = ST_FINISH;
          end else if (req_i.opcode <= OP_SHOW) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (req_q.opcode == OP_CREATE ? !valid_q[slot_q] : match_c) state_d = ST_FINISH;
        else if (last_c) state_d = ST_FINISH;
      end
      ST_RC_TEST: begin
        if (cand_c) state_d = ST_RC_X;
        else if (last_c) state_d = ST_FINISH;
      end
      ST_RC_X:    if (md_rsp.done) state_d = ST_RC_Y;
      ST_RC_Y:    if (md_rsp.done) state_d = ST_RC_EVAL;
      ST_RC_EVAL: state_d = last_c ? ST_FINISH : ST_RC_TEST;
      ST_FINISH:  if (!rsp_valid_q || rsp_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      valid_q     <= '0;
      shown_q     <= '0;
      pinned_q    <= '0;
      id_ctr_q    <= 32'd1;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FINISH && (!rsp_valid_q || rsp_ready_i)) rsp_valid_q <= 1'b1;
      else if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      if (accept) found_q <= 1'b0;
      if (state_q == ST_RC_EVAL && in_c && better_c) found_q <= 1'b1;
      if (state_q == ST_SCAN) begin
        if (req_q.opcode == OP_CREATE) begin
          if (!valid_q[slot_q]) begin
            valid_q[slot_q]  <= 1'b1;
            shown_q[slot_q]  <= 1'b1;
            pinned_q[slot_q] <= 1'b0;
            id_ctr_q         <= id_next;
          end
        end else if (match_c) begin
          case (req_q.opcode)
            OP_SET_POS: pinned_q[slot_q] <= 1'b0;
            OP_PIN:     pinned_q[slot_q] <= 1'b1;
            default:    shown_q[slot_q]  <= req_q.visible;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_q  <= req_i;
          slot_q <= '0;
          res_q  <= {req_i.opcode > OP_RAYCAST, ($bits(rsp_t) - 1)'(0)};
        end
      end
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_ready_i) rsp_q <= rsp_d;
      end
      ST_SCAN: begin
        if (req_q.opcode == OP_CREATE) begin
          if (!valid_q[slot_q]) begin
            owner_q[slot_q]    <= id_ctr_q;
            cx_q[slot_q]       <= req_q.vec_x;
            cy_q[slot_q]       <= req_q.vec_y;
            cz_q[slot_q]       <= req_q.vec_z;
            ew_q[slot_q]       <= req_q.width;
            eh_q[slot_q]       <= req_q.height;
            res_q.new_panel_id <= id_ctr_q;
          end else if (last_c) begin
            res_q.status <= 1'b1;
          end else begin
            slot_q <= slot_q + SLOT_W'(1);
          end
        end else if (match_c) begin
          if (req_q.opcode == OP_SET_POS) begin
            cx_q[slot_q] <= req_q.vec_x;
            cy_q[slot_q] <= req_q.vec_y;
            cz_q[slot_q] <= req_q.vec_z;
          end else if (req_q.opcode == OP_PIN) begin
            cz_q[slot_q] <= -$signed({1'b0, req_q.distance});
          end
        end else if (last_c) begin
          res_q.status <= 1'b1;
        end else begin
          slot_q <= slot_q + SLOT_W'(1);
        end
      end
      ST_RC_TEST: begin
        num_q <= num_c;
        if (!cand_c && !last_c) slot_q <= slot_q + SLOT_W'(1);
      end
      ST_RC_X: begin
        if (md_rsp.done) offx_q <= off_c;
      end
      ST_RC_Y: begin
        if (md_rsp.done) begin
          hx_q <= px_c;
          hy_q <= py_c;
        end
      end
      ST_RC_EVAL: begin
        if (!last_c) slot_q <= slot_q + SLOT_W'(1);
      end
      default: begin
      end
    endcase
    if (state_q == ST_RC_EVAL && in_c && better_c) begin
      best_q <= num_q_mag;
      bid_q  <= owner_q[slot_q];
      bx_q   <= hx_q;
      by_q   <= hy_q;
      bz_q   <= cz_q[slot_q];
    end
  end

  ap_eval_live_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RC_EVAL |-> valid_q[slot_q] && shown_q[slot_q])
    else $error("evaluating a free or hidden slot");
  ap_found_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> bid_q != '0)
    else $error("nearest hit without panel id");
  ap_ray_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RC_X || state_q == ST_RC_Y) |-> req_q.opcode == OP_RAYCAST)
    else $error("ray unit busy on a table operation");
  ap_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_ctr_q != '0)
    else $error("id counter reached zero");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the panel table ray hit test block.
`timescale 1ns / 100ps

class panel_scoreboard;
  logic [31:0] owner [32];
  logic signed [31:0] cx [32];
  logic signed [31:0] cy [32];
  logic signed [31:0] cz [32];
  logic [30:0] ew [32];
  logic [30:0] eh [32];
  bit shown [32];
  bit pinned [32];
  logic [31:0] next_id;
  int used;
  ptrh_pkg::rsp_t expected_q[$];
  int errors;

  function new();
    for (int i = 0; i < 32; i++) begin
      owner[i] = 0; cx[i] = 0; cy[i] = 0; cz[i] = 0; ew[i] = 0; eh[i] = 0;
      shown[i] = 0; pinned[i] = 0;
    end
    next_id = 1;
    used = 0;
    errors = 0;
  endfunction

  function longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function longint ray_offset(longint d, longint num, longint dz);
    bit neg;
    longint unsigned m;
    neg = (d < 0) != (num < 0);
    if (dz < 0) neg = !neg;
    m = (mag(d) * mag(num)) / mag(dz);
    if (m > (64'd1 << 40)) m = 64'd1 << 40;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function logic [31:0] sat(longint v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function int lookup(logic [31:0] id);
    if (id == 0) return -1;
    for (int i = 0; i < 32; i++)
      if (owner[i] == id) return i;
    return -1;
  endfunction

  function void note_request(ptrh_pkg::req_t r);
    ptrh_pkg::rsp_t e;
    int s;
    bit found;
    longint unsigned best, unsigned_num;
    longint num, ox, oy, lx, ly, vx, vy, vz, dz;
    e = '0;
    vx = r.vec_x; vy = r.vec_y; vz = r.vec_z; dz = r.dir_z;
    case (r.opcode)
      ptrh_pkg::OP_CREATE: begin
        s = -1;
        if (used < 32)
          for (int i = 0; i < 32; i++)
            if (s < 0 && owner[i] == 0) s = i;
        if (s < 0) e.status = 1;
        else begin
          owner[s] = next_id;
          e.new_panel_id = next_id;
          next_id = next_id + 1;
          if (next_id == 0) next_id = 1;
          cx[s] = r.vec_x; cy[s] = r.vec_y; cz[s] = r.vec_z;
          ew[s] = r.width; eh[s] = r.height;
          shown[s] = 1; pinned[s] = 0;
          used++;
        end
      end
      ptrh_pkg::OP_SET_POS, ptrh_pkg::OP_PIN, ptrh_pkg::OP_SHOW: begin
        s = lookup(r.panel_id);
        if (s < 0) e.status = 1;
        else if (r.opcode == ptrh_pkg::OP_SET_POS) begin
          cx[s] = r.vec_x; cy[s] = r.vec_y; cz[s] = r.vec_z; pinned[s] = 0;
        end else if (r.opcode == ptrh_pkg::OP_PIN) begin
          cz[s] = -$signed({1'b0, r.distance}); pinned[s] = 1;
        end else shown[s] = r.visible;
      end
      ptrh_pkg::OP_RAYCAST: begin
        found = 0;
        best = 0;
        if (mag(dz) >= ptrh_pkg::MIN_DZ)
          for (int i = 0; i < 32; i++) begin
            if (owner[i] == 0 || !shown[i]) continue;
            num = longint'(cz[i]) - vz;
            if (num != 0 && ((num < 0) != (dz < 0))) continue;
            ox = ray_offset(longint'(r.dir_x), num, dz);
            oy = ray_offset(longint'(r.dir_y), num, dz);
            lx = vx + ox - longint'(cx[i]);
            ly = vy + oy - longint'(cy[i]);
            if (2 * mag(lx) > longint'(ew[i])) continue;
            if (2 * mag(ly) > longint'(eh[i])) continue;
            unsigned_num = mag(num);
            if (!found || unsigned_num < best) begin
              found = 1;
              best = unsigned_num;
              e.hit = 1;
              e.hit_panel_id = owner[i];
              e.hit_x = sat(vx + ox);
              e.hit_y = sat(vy + oy);
              e.hit_z = cz[i];
            end
          end
      end
      default: e.status = 1;
    endcase
    expected_q.push_back(e);
  endfunction

  function void compare(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %h, actual %h", name, exp, act);
      errors++;
    end
  endfunction

  function void check_response(ptrh_pkg::rsp_t a);
    ptrh_pkg::rsp_t e;
    if (expected_q.size() == 0) begin
      $error("response with no request waiting: %h", a);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    compare("status", e.status, a.status);
    compare("new_panel_id", e.new_panel_id, a.new_panel_id);
    compare("hit", e.hit, a.hit);
    compare("hit_panel_id", e.hit_panel_id, a.hit_panel_id);
    compare("hit_x", e.hit_x, a.hit_x);
    compare("hit_y", e.hit_y, a.hit_y);
    compare("hit_z", e.hit_z, a.hit_z);
  endfunction
endclass

module testbench;
  import ptrh_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic req_valid_i = 0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 0;
  rsp_t rsp_o;
  bit calm = 0;
  panel_scoreboard sb = new();

  panel_table_ray_hit_test dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rsp_valid_o && rsp_ready_i) sb.check_response(rsp_o);
    rsp_ready_i <= calm || ($urandom_range(99) >= 21);
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

  task automatic send(req_t r);
    int gap;
    req_valid_i <= 1;
    req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_request(r);
    gap = (!calm && $urandom_range(99) < 21) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      req_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic req_t noise();
    req_t r;
    r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom});
    return r;
  endfunction

  function automatic req_t op_req(logic [2:0] op, logic [31:0] id);
    req_t r;
    r = noise();
    r.opcode = op;
    r.panel_id = id;
    return r;
  endfunction

  function automatic logic [31:0] some_id();
    logic [31:0] id;
    id = sb.owner[$urandom_range(31)];
    return id != 0 ? id : sb.next_id - 1;
  endfunction

  function automatic req_t aimed_ray();
    req_t r;
    int s;
    s = $urandom_range(31);
    r = op_req(OP_RAYCAST, 0);
    r.vec_x = sb.cx[s] + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    r.vec_y = sb.cy[s] + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    r.vec_z = sb.cz[s] - $signed($urandom_range(0, 1 << 21));
    r.dir_x = $signed($urandom_range(0, 1 << 15)) - (1 << 14);
    r.dir_y = $signed($urandom_range(0, 1 << 15)) - (1 << 14);
    r.dir_z = $urandom_range(MIN_DZ, 1 << 17);
    if ($urandom_range(3) == 0) begin
      r.vec_z = sb.cz[s] + $signed($urandom_range(0, 1 << 21));
      r.dir_z = -r.dir_z;
    end
    return r;
  endfunction

  initial begin
    req_t r;
    int p;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    r = op_req(OP_RAYCAST, 0);
    r.dir_z = 1 << 16;
    send(r);
    r = op_req(OP_CREATE, 0);
    r.vec_x = 0; r.vec_y = 0; r.vec_z = 32'sh00050000;
    r.width = 31'h7FFFFFFF; r.height = 31'h7FFFFFFF;
    send(r);
    r.vec_z = 32'sh00030000; r.width = 31'h00040000; r.height = 31'h00040000;
    send(r);
    r.vec_z = 32'sh00030000;
    send(r);
    r = op_req(OP_CREATE, 0);
    r.vec_x = 32'sh7FFFFFFF; r.vec_y = 32'sh80000000; r.vec_z = 32'sh80000000;
    r.width = 0; r.height = 0;
    send(r);
    r = op_req(OP_RAYCAST, 0);
    r.vec_x = 0; r.vec_y = 0; r.vec_z = 0; r.dir_x = 0; r.dir_y = 0;
    r.dir_z = MIN_DZ - 1; send(r);
    r.dir_z = MIN_DZ; send(r);
    r.dir_z = -MIN_DZ; send(r);
    r.dir_z = 32'sh80000000; send(r);
    r.dir_z = 32'sh7FFFFFFF; r.dir_x = 32'sh7FFFFFFF; r.dir_y = 32'sh80000000;
    send(r);
    r.vec_z = 32'sh00030000; r.dir_x = 0; r.dir_y = 0; r.dir_z = 1;
    send(r);
    send(op_req(OP_SET_POS, 0));
    send(op_req(OP_SET_POS, 32'hFFFFFFFF));
    r = op_req(OP_PIN, 1); r.distance = 31'h7FFFFFFF; send(r);
    r = op_req(OP_PIN, 2); r.distance = 0; send(r);
    r = op_req(OP_SHOW, 3); r.visible = 0; send(r);
    r = op_req(OP_SHOW, 3); r.visible = 1; send(r);
    r = op_req(OP_SET_POS, 4); send(r);
    for (int k = 5; k <= 7; k++) send(op_req(3'(k), 1));
    send(aimed_ray());

    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 400 && n < 520);
      p = $urandom_range(99);
      if (p < 10) begin
        r = op_req(OP_CREATE, 0);
        if ($urandom_range(3) != 0) begin
          r.vec_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          r.vec_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          r.vec_z = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          r.width = $urandom_range(0, 1 << 21);
          r.height = $urandom_range(0, 1 << 21);
        end
      end else if (p < 20) begin
        r = op_req(OP_SET_POS, some_id());
        r.vec_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        r.vec_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        r.vec_z = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      end else if (p < 27) begin
        r = op_req(OP_PIN, some_id());
        if ($urandom_range(3) != 0) r.distance = $urandom_range(0, 1 << 21);
      end else if (p < 36) begin
        r = op_req(OP_SHOW, some_id());
        r.visible = $urandom_range(99) < 70;
      end else if (p < 80) r = aimed_ray();
      else if (p < 88) r = op_req(OP_RAYCAST, 0);
      else if (p < 97) r = op_req(3'($urandom_range(OP_SET_POS, OP_SHOW)), $urandom);
      else r = op_req(3'($urandom_range(OP_RAYCAST + 1, 7)), $urandom);
      send(r);
    end
    req_valid_i <= 0;
    calm = 0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ----- panel_table_ray_hit_test.f -----
rtl/core/ptrh_pkg.sv
rtl/core/ptrh_muldiv.sv
rtl/core/panel_table_ray_hit_test.sv
dv/testbench.sv
